// ----- design/filled_circle_span_rasterizer_macros.svh -----
// Assertion macros shared by the span rasterizer modules.
// No dependencies; included by files that carry concurrent checks.
`ifndef FILLED_CIRCLE_SPAN_RASTERIZER_MACROS_SVH
`define FILLED_CIRCLE_SPAN_RASTERIZER_MACROS_SVH

// check the consequent in the same cycle as the antecedent
`define FCSR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcsr: check failed");

// check the consequent in the cycle after the antecedent
`define FCSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcsr: check failed");

`endif

// ----- design/fcsr_pkg.sv -----
// Package for the filled circle span rasterizer: widths, codes, command types.
// No dependencies; imported by the datapath, controller and top level.
package fcsr_pkg;

    localparam int DEF_COORD_WIDTH    = 16;
    localparam int DEF_ZOOM_FRAC_BITS = 8;

    localparam int COORD_IN_W = 16;
    localparam int RADIUS_W   = 14;
    localparam int COLOR_W    = 24;
    localparam int ZOOM_W     = 16;
    localparam int OUT_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MUL_IN_W   = 17;
    localparam int PROD_W     = 2 * MUL_IN_W;

    localparam logic [ZOOM_W-1:0] ZOOM_RESET = 16'd256;

    localparam int DEC_INIT     = 3;
    localparam int DEC_STEP_IN  = 6;
    localparam int DEC_STEP_OUT = 10;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ZOOM  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAN_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAN_Y = 2'd2;

    localparam logic [1:0] SPAN_FIRST = 2'd0;
    localparam logic [1:0] SPAN_LAST  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP_X,
        ST_MAP_Y,
        ST_MAP_R,
        ST_MAP_END,
        ST_SPAN,
        ST_FIN
    } ctrl_state_t;

    typedef enum logic [1:0] {
        SEL_X,
        SEL_Y,
        SEL_R
    } coord_sel_t;

    typedef struct packed {
        logic       capture;
        logic       mul_en;
        coord_sel_t mul_sel;
        logic       fin_en;
        coord_sel_t fin_sel;
        logic       load_span;
        logic [1:0] span_idx;
        logic       load_fin;
        logic       step;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
        logic slot_free;
    } dp_status_t;

endpackage

// ----- design/fcsr_datapath.sv -----
// Datapath: configuration registers, shared zoom multiplier, circle state and
// the output beat register. Depends on fcsr_pkg and the assertion macros.
`include "filled_circle_span_rasterizer_macros.svh"

module fcsr_datapath
    import fcsr_pkg::*;
#(
    parameter int COORD_WIDTH    = DEF_COORD_WIDTH,
    parameter int ZOOM_FRAC_BITS = DEF_ZOOM_FRAC_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic signed [COORD_IN_W-1:0] center_x,
    input  logic signed [COORD_IN_W-1:0] center_y,
    input  logic [RADIUS_W-1:0]          radius,
    input  logic [COLOR_W-1:0]           fill_rgb,
    input  dp_cmd_t                      cmd,
    output dp_status_t                   status,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic signed [OUT_W-1:0]      row,
    output logic signed [OUT_W-1:0]      span_left,
    output logic signed [OUT_W-1:0]      span_right,
    output logic [COLOR_W-1:0]           span_color,
    output logic                         last_of_group,
    output logic                         finished
);

    localparam int X_W   = COORD_WIDTH + 1;
    localparam int D_W   = COORD_WIDTH + 4;
    localparam int ACC_W = ((PROD_W > COORD_IN_W + ZOOM_FRAC_BITS) ?
                            PROD_W : COORD_IN_W + ZOOM_FRAC_BITS) + 1;
    localparam int Q_W   = ACC_W - ZOOM_FRAC_BITS;
    localparam int SAT_W = ((Q_W > COORD_WIDTH + 2) ? Q_W : COORD_WIDTH + 2) + 1;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS =
        ACC_W'((1 << ZOOM_FRAC_BITS) - 1);
    localparam logic signed [SAT_W-1:0] SAT_HI =
        {{(SAT_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [SAT_W-1:0] SAT_LO = ~SAT_HI;

    function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
        input logic signed [SAT_W-1:0] v
    );
        if (v > SAT_HI)
        begin
            return COORD_WIDTH'(SAT_HI);
        end
        else if (v < SAT_LO)
        begin
            return COORD_WIDTH'(SAT_LO);
        end
        return COORD_WIDTH'(v);
    endfunction

    logic [ZOOM_W-1:0]                zoom_reg;
    logic signed [CFG_DATA_W-1:0]     pan_x_reg;
    logic signed [CFG_DATA_W-1:0]     pan_y_reg;
    logic signed [COORD_IN_W-1:0]     cx_in_reg;
    logic signed [COORD_IN_W-1:0]     cy_in_reg;
    logic [RADIUS_W-1:0]              r_in_reg;
    logic [COLOR_W-1:0]               active_color_reg;
    logic signed [PROD_W-1:0]         prod_reg;
    logic signed [PROD_W-1:0]         prod_next;
    logic signed [COORD_WIDTH-1:0]    scx_reg;
    logic signed [COORD_WIDTH-1:0]    scy_reg;
    logic signed [X_W-1:0]            step_x_reg;
    logic signed [X_W-1:0]            step_y_reg;
    logic signed [D_W-1:0]            decision_reg;
    logic signed [D_W-1:0]            decision_next;
    logic                             busy_reg;

    logic signed [MUL_IN_W-1:0]       mul_a;
    logic signed [MUL_IN_W-1:0]       mul_b;
    logic signed [CFG_DATA_W-1:0]     pan_sel;
    logic signed [ACC_W-1:0]          acc;
    logic signed [ACC_W-1:0]          acc_adj;
    logic signed [SAT_W-1:0]          q_ext;
    logic signed [COORD_WIDTH-1:0]    mapped;

    logic signed [X_W-1:0]            row_off;
    logic signed [X_W-1:0]            col_off;
    logic signed [SAT_W-1:0]          row_sum;
    logic signed [SAT_W-1:0]          left_sum;
    logic signed [SAT_W-1:0]          right_sum;
    logic signed [D_W-1:0]            x_d;
    logic signed [D_W-1:0]            y_d;

    logic                             out_valid_reg;
    logic signed [OUT_W-1:0]          row_reg;
    logic signed [OUT_W-1:0]          left_reg;
    logic signed [OUT_W-1:0]          right_reg;
    logic [COLOR_W-1:0]               color_reg;
    logic                             last_reg;
    logic                             finished_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zoom_reg  <= ZOOM_RESET;
            pan_x_reg <= '0;
            pan_y_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ZOOM:  zoom_reg  <= cfg_data;
                REG_PAN_X: pan_x_reg <= cfg_data;
                REG_PAN_Y: pan_y_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // shared multiplier, operand picked by the controller
    always_comb
    begin
        case (cmd.mul_sel)
            SEL_X:   mul_a = MUL_IN_W'(cx_in_reg);
            SEL_Y:   mul_a = MUL_IN_W'(cy_in_reg);
            SEL_R:   mul_a = {{(MUL_IN_W - RADIUS_W){1'b0}}, r_in_reg};
            default: mul_a = '0;
        endcase
        mul_b     = {1'b0, zoom_reg};
        prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // add pan, truncate toward zero, saturate
    always_comb
    begin
        case (cmd.fin_sel)
            SEL_X:   pan_sel = pan_x_reg;
            SEL_Y:   pan_sel = pan_y_reg;
            default: pan_sel = '0;
        endcase
        acc     = ACC_W'(prod_reg) + (ACC_W'(pan_sel) <<< ZOOM_FRAC_BITS);
        acc_adj = acc + (acc[ACC_W-1] ? ROUND_BIAS : '0);
        q_ext   = SAT_W'(acc_adj >>> ZOOM_FRAC_BITS);
        mapped  = sat_coord(q_ext);
    end

    always_comb
    begin
        row_off   = cmd.span_idx[1] ? step_x_reg : step_y_reg;
        col_off   = cmd.span_idx[1] ? step_y_reg : step_x_reg;
        row_sum   = cmd.span_idx[0] ? SAT_W'(scy_reg) - SAT_W'(row_off)
                                    : SAT_W'(scy_reg) + SAT_W'(row_off);
        left_sum  = SAT_W'(scx_reg) - SAT_W'(col_off);
        right_sum = SAT_W'(scx_reg) + SAT_W'(col_off);
    end

    always_comb
    begin
        x_d = D_W'(step_x_reg);
        y_d = D_W'(step_y_reg);
        if (decision_reg[D_W-1])
        begin
            decision_next = decision_reg + (x_d <<< 2) + D_W'(DEC_STEP_IN);
        end
        else
        begin
            decision_next = decision_reg + ((x_d - y_d) <<< 2) + D_W'(DEC_STEP_OUT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cx_in_reg        <= center_x;
            cy_in_reg        <= center_y;
            r_in_reg         <= radius;
            active_color_reg <= fill_rgb;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.fin_en)
        begin
            case (cmd.fin_sel)
                SEL_X: scx_reg <= mapped;
                SEL_Y: scy_reg <= mapped;
                SEL_R:
                begin
                    step_x_reg   <= '0;
                    step_y_reg   <= X_W'(mapped);
                    decision_reg <= D_W'(DEC_INIT) - (D_W'(mapped) <<< 1);
                end
                default: ;
            endcase
        end
        if (cmd.step)
        begin
            decision_reg <= decision_next;
            step_x_reg   <= step_x_reg + X_W'(1);
            if (!decision_reg[D_W-1])
            begin
                step_y_reg <= step_y_reg - X_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (cmd.fin_en && cmd.fin_sel == SEL_R)
        begin
            busy_reg <= 1'b1;
        end
        else if (cmd.load_fin)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_span || cmd.load_fin)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_span)
        begin
            row_reg      <= OUT_W'(sat_coord(row_sum));
            left_reg     <= OUT_W'(sat_coord(left_sum));
            right_reg    <= OUT_W'(sat_coord(right_sum));
            color_reg    <= active_color_reg;
            last_reg     <= (cmd.span_idx == SPAN_LAST);
            finished_reg <= 1'b0;
        end
        else if (cmd.load_fin)
        begin
            row_reg      <= '0;
            left_reg     <= '0;
            right_reg    <= '0;
            color_reg    <= '0;
            last_reg     <= 1'b1;
            finished_reg <= 1'b1;
        end
    end

    assign status.done      = !busy_reg || (step_x_reg > step_y_reg);
    assign status.slot_free = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign row           = row_reg;
    assign span_left     = left_reg;
    assign span_right    = right_reg;
    assign span_color    = color_reg;
    assign last_of_group = last_reg;
    assign finished      = finished_reg;

    `FCSR_ASSERT_NOW(a_no_overwrite, clk, rst_n, out_valid_reg && !out_ready, !(cmd.load_span || cmd.load_fin))
    `FCSR_ASSERT_NEXT(a_fin_clears, clk, rst_n, cmd.load_fin, !busy_reg && out_valid_reg && finished_reg)
    `FCSR_ASSERT_NEXT(a_step_x, clk, rst_n, cmd.step, step_x_reg == $past(step_x_reg) + X_W'(1))

endmodule

// ----- design/fcsr_ctrl.sv -----
// Controller: sequences the start mapping, and the span beats or finished beat of an advance.
// Depends on fcsr_pkg and the assertion macros.
`include "filled_circle_span_rasterizer_macros.svh"

module fcsr_ctrl
    import fcsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       opcode,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic [1:0]  idx_reg;
    logic [1:0]  idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= SPAN_FIRST;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        in_ready      = 1'b0;
        cmd.capture   = 1'b0;
        cmd.mul_en    = 1'b0;
        cmd.mul_sel   = SEL_X;
        cmd.fin_en    = 1'b0;
        cmd.fin_sel   = SEL_X;
        cmd.load_span = 1'b0;
        cmd.span_idx  = idx_reg;
        cmd.load_fin  = 1'b0;
        cmd.step      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (opcode == OP_START)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_MAP_X;
                    end
                    else if (status.done)
                    begin
                        if (status.slot_free)
                        begin
                            cmd.load_fin = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_FIN;
                        end
                    end
                    else
                    begin
                        // emit the first span straight away when the slot is free
                        cmd.span_idx = SPAN_FIRST;
                        state_next   = ST_SPAN;
                        if (status.slot_free)
                        begin
                            cmd.load_span = 1'b1;
                            idx_next      = SPAN_FIRST + 2'd1;
                        end
                        else
                        begin
                            idx_next = SPAN_FIRST;
                        end
                    end
                end
            end
            ST_MAP_X:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = SEL_X;
                state_next  = ST_MAP_Y;
            end
            ST_MAP_Y:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = SEL_Y;
                cmd.fin_en  = 1'b1;
                cmd.fin_sel = SEL_X;
                state_next  = ST_MAP_R;
            end
            ST_MAP_R:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = SEL_R;
                cmd.fin_en  = 1'b1;
                cmd.fin_sel = SEL_Y;
                state_next  = ST_MAP_END;
            end
            ST_MAP_END:
            begin
                cmd.fin_en  = 1'b1;
                cmd.fin_sel = SEL_R;
                state_next  = ST_IDLE;
            end
            ST_SPAN:
            begin
                if (status.slot_free)
                begin
                    cmd.load_span = 1'b1;
                    if (idx_reg == SPAN_LAST)
                    begin
                        cmd.step   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end
            ST_FIN:
            begin
                if (status.slot_free)
                begin
                    cmd.load_fin = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `FCSR_ASSERT_NOW(a_step_on_last, clk, rst_n, cmd.step, cmd.load_span && cmd.span_idx == SPAN_LAST)
    `FCSR_ASSERT_NEXT(a_span_advance, clk, rst_n, state_reg == ST_SPAN && status.slot_free && idx_reg != SPAN_LAST, state_reg == ST_SPAN && idx_reg == $past(idx_reg) + 2'd1)

endmodule

// ----- design/filled_circle_span_rasterizer.sv -----
// Filled circle span rasterizer. A start beat (opcode 0) maps the circle to
// screen space through one shared 17x17 multiplier used in turn for centre x,
// centre y and radius, stepping through ST_MAP_X, ST_MAP_Y, ST_MAP_R and
// ST_MAP_END before it is ready again. An advance beat (opcode 1) yields four
// span beats through the single output register, one per cycle while the output
// is not stalled, or one finished beat once the circle is done. Configuration
// writes are taken in any cycle.
// Depends on fcsr_pkg, fcsr_datapath and fcsr_ctrl.
module filled_circle_span_rasterizer
    import fcsr_pkg::*;
#(
    parameter int COORD_WIDTH    = DEF_COORD_WIDTH,
    parameter int ZOOM_FRAC_BITS = DEF_ZOOM_FRAC_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         opcode,
    input  logic signed [COORD_IN_W-1:0] center_x,
    input  logic signed [COORD_IN_W-1:0] center_y,
    input  logic [RADIUS_W-1:0]          radius,
    input  logic [COLOR_W-1:0]           fill_rgb,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [OUT_W-1:0]      row,
    output logic signed [OUT_W-1:0]      span_left,
    output logic signed [OUT_W-1:0]      span_right,
    output logic [COLOR_W-1:0]           span_color,
    output logic                         last_of_group,
    output logic                         finished
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    fcsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    fcsr_datapath #(
        .COORD_WIDTH    (COORD_WIDTH),
        .ZOOM_FRAC_BITS (ZOOM_FRAC_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .center_x      (center_x),
        .center_y      (center_y),
        .radius        (radius),
        .fill_rgb      (fill_rgb),
        .cmd           (cmd),
        .status        (status),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .row           (row),
        .span_left     (span_left),
        .span_right    (span_right),
        .span_color    (span_color),
        .last_of_group (last_of_group),
        .finished      (finished)
    );

endmodule
